// ----- hdl/granular_pitch_shifter_assert.svh -----
// assertion macros for the granular pitch shifter
// used by modules that clock on i_clk and reset on i_rst_n
`ifndef GRANULAR_PITCH_SHIFTER_ASSERT_SVH
`define GRANULAR_PITCH_SHIFTER_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GPS_ASSERT_IMP(lbl, ante, cons, msg)
`define GPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/gps_pkg.sv -----
// shared constants, types and helpers for the granular pitch shifter
// no dependencies
package gps_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int BUF_DEPTH    = 4096;
    localparam int GRAIN_LEN    = 1024;
    localparam int START_DELAY  = 2048;
    localparam int GRAIN_COUNT  = 4;
    localparam int FRAC_BITS    = 16;
    localparam int ADDR_BITS    = $clog2(BUF_DEPTH);
    localparam int PHASE_BITS   = $clog2(GRAIN_LEN);
    localparam int GRAIN_BITS   = $clog2(GRAIN_COUNT);
    localparam int POS_BITS     = ADDR_BITS + FRAC_BITS;
    localparam int MUL_BITS     = 33;
    localparam int PROD_BITS    = 2 * MUL_BITS;

    localparam int RATIO_BITS   = 18;
    localparam int MIX_BITS     = 17;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 18;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH_RATIO   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WET_MIX       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EFFECT_ENABLE = 2'd2;

    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 18'd65536;
    localparam logic [MIX_BITS-1:0]   WET_RESET   = 17'd32768;
    localparam logic [MIX_BITS-1:0]   MIX_ONE     = 17'd65536;

    // sine polynomial coefficients, q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026996;
    localparam logic [31:0] SIN_C9 = 32'd172273;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [MUL_BITS-1:0] a;
        logic signed [MUL_BITS-1:0] b;
    } t_mul_req;

    // grain start position after reset, uses the reset ratio
    function automatic logic [POS_BITS-1:0] init_pos(input int g);
        logic [63:0] v;
        v = (64'((BUF_DEPTH - START_DELAY % BUF_DEPTH) % BUF_DEPTH) << FRAC_BITS)
            + 64'(g) * 64'(GRAIN_LEN / GRAIN_COUNT) * 64'(RATIO_RESET);
        return v[POS_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > 32'(SAMPLE_MAX)) begin
            res = SAMPLE_MAX;
        end else if (v < 32'(SAMPLE_MIN)) begin
            res = SAMPLE_MIN;
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hdl/gps_ram.sv -----
// sample store: one write port, two registered read ports
// no dependencies
module gps_ram #(
    parameter int WIDTH     = 48,
    parameter int ADDR_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr_a,
    input  logic [ADDR_BITS-1:0] i_raddr_b,
    output logic [WIDTH-1:0]     o_rdata_a,
    output logic [WIDTH-1:0]     o_rdata_b
);

    logic [WIDTH-1:0] r_mem [1 << ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- hdl/gps_mul.sv -----
// shared signed multiplier with registered product
// depends on gps_pkg
module gps_mul (
    input  logic                                   i_clk,
    input  gps_pkg::t_mul_req                      i_req,
    output logic signed [gps_pkg::PROD_BITS-1:0]   o_prod
);

    import gps_pkg::*;

    always_ff @(posedge i_clk) begin
        o_prod <= i_req.a * i_req.b;
    end

endmodule

// ----- hdl/granular_pitch_shifter.sv -----
// granular pitch shifter top level: sequencer, grain state and mixing
// depends on gps_pkg, gps_ram, gps_mul and granular_pitch_shifter_assert.svh
//
// channel   direction  handshake                  word
// in        sink       i_in_valid / o_in_stall    left, right sample, end of block
// out       source     o_out_valid / i_out_stall  left, right mix, end of block
// cfg       sink       i_cfg_valid / o_cfg_ready  register index and data
//
// after reset the store is cleared, all 4096 addresses, one address a cycle, with o_in_stall high
// an enabled word runs on the shared multiplier: 11 multiplies and one add per grain, for
// each of the 4 grains, then 4 multiplies to mix; no new word is taken until its result
// is in the output register; a disabled word goes straight to that load, grain state untouched
// the result waits in the output register, a new word is taken meanwhile; a finished
// result waits for that register if it is still stalled
`include "granular_pitch_shifter_assert.svh"
module granular_pitch_shifter (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic signed [gps_pkg::SAMPLE_BITS-1:0]    i_left_sample,
    input  logic signed [gps_pkg::SAMPLE_BITS-1:0]    i_right_sample,
    input  logic                                      i_end_of_block,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [gps_pkg::SAMPLE_BITS-1:0]    o_left_out,
    output logic signed [gps_pkg::SAMPLE_BITS-1:0]    o_right_out,
    output logic                                      o_block_end_out,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [gps_pkg::CFG_IDX_BITS-1:0]          i_cfg_index,
    input  logic [gps_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    import gps_pkg::*;

    typedef enum logic [19:0] {
        S_CLEAR = 20'd1 << 0,
        S_IDLE  = 20'd1 << 1,
        S_X2    = 20'd1 << 2,
        S_H7    = 20'd1 << 3,
        S_H5    = 20'd1 << 4,
        S_H3    = 20'd1 << 5,
        S_H1    = 20'd1 << 6,
        S_S     = 20'd1 << 7,
        S_SQ    = 20'd1 << 8,
        S_W     = 20'd1 << 9,
        S_IL    = 20'd1 << 10,
        S_IR    = 20'd1 << 11,
        S_AL    = 20'd1 << 12,
        S_AR    = 20'd1 << 13,
        S_ML    = 20'd1 << 14,
        S_ML2   = 20'd1 << 15,
        S_MR    = 20'd1 << 16,
        S_MR2   = 20'd1 << 17,
        S_MF    = 20'd1 << 18,
        S_FIN   = 20'd1 << 19
    } t_state;

    localparam int SB = SAMPLE_BITS;

    t_state r_state, n_state;

    // configuration
    logic [RATIO_BITS-1:0] r_ratio;
    logic [MIX_BITS-1:0]   r_wet;
    logic                  r_en;

    // grain and store state
    logic [ADDR_BITS-1:0]  r_clr;
    logic [ADDR_BITS-1:0]  r_wpos;
    logic [PHASE_BITS-1:0] r_phase;
    logic [GRAIN_BITS-1:0] r_grain;
    logic [POS_BITS-1:0]   r_pos [GRAIN_COUNT];

    // working registers
    logic signed [SB-1:0]  r_l, r_r;
    logic                  r_eob;
    logic [30:0]           r_x2;
    logic [16:0]           r_win;
    logic signed [SB-1:0]  r_il, r_ir;
    logic signed [44:0]    r_accl, r_accr;
    logic signed [47:0]    r_mix;
    logic signed [SB-1:0]  r_resl, r_resr;

    // output register
    logic                  r_out_valid;
    logic signed [SB-1:0]  r_out_l, r_out_r;
    logic                  r_out_eob;

    logic                        in_acc, out_acc, out_load;
    t_mul_req                    mreq;
    logic signed [PROD_BITS-1:0] prod;
    logic [PHASE_BITS-1:0]       ph, tw;
    logic [POS_BITS-1:0]         cur_pos;
    logic [ADDR_BITS-1:0]        ia, ib, dpos;
    logic [FRAC_BITS-1:0]        frac;
    logic [2*SB-1:0]             rda, rdb;
    logic signed [SB-1:0]        al, bl, ar, br;
    logic signed [SB:0]          diff_l, diff_r;
    logic [30:0]                 hor, x2n, s_raw, s_cl;
    logic [MIX_BITS-1:0]         wet_c, dry_c;
    logic signed [27:0]          sl, sr;
    logic signed [47:0]          mix_sum;
    logic                        ram_we;
    logic [ADDR_BITS-1:0]        ram_waddr;
    logic [2*SB-1:0]             ram_wdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_out_l;
    assign o_right_out     = r_out_r;
    assign o_block_end_out = r_out_eob;

    // phase of the current grain and its distance from the nearer grain edge
    assign ph = r_phase + {r_grain, {(PHASE_BITS-GRAIN_BITS){1'b0}}};
    assign tw = (ph > PHASE_BITS'(GRAIN_LEN / 2)) ? PHASE_BITS'(0) - ph : ph;

    assign cur_pos = r_pos[r_grain];
    assign ia      = cur_pos[POS_BITS-1:FRAC_BITS];
    assign ib      = ia + 1'b1;
    assign frac    = cur_pos[FRAC_BITS-1:0];
    // read head restart point, write pointer already advanced
    assign dpos    = r_wpos - ADDR_BITS'(START_DELAY % BUF_DEPTH);

    assign al = rda[2*SB-1:SB];
    assign ar = rda[SB-1:0];
    assign bl = rdb[2*SB-1:SB];
    assign br = rdb[SB-1:0];
    assign diff_l = {bl[SB-1], bl} - {al[SB-1], al};
    assign diff_r = {br[SB-1], br} - {ar[SB-1], ar};

    // horner step term, window terms
    assign hor   = prod[60:30];
    assign x2n   = {prod[18:0], 12'b0};
    assign s_raw = prod[39:9];
    assign s_cl  = (s_raw > 31'(1 << 30)) ? 31'(1 << 30) : s_raw;

    assign wet_c = (r_wet > MIX_ONE) ? MIX_ONE : r_wet;
    assign dry_c = MIX_ONE - wet_c;
    assign sl    = r_accl[44:17];
    assign sr    = r_accr[44:17];
    assign mix_sum = r_mix + prod[47:0];

    // store write: clearing pass or the incoming pair
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wpos;
        ram_wdata = {i_left_sample, i_right_sample};
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (in_acc && r_en) begin
            ram_we = 1'b1;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mreq.a = '0;
        mreq.b = '0;
        case (r_state)
            S_X2: begin
                mreq.a = MUL_BITS'(tw);
                mreq.b = MUL_BITS'(tw);
            end
            S_H7: begin
                mreq.a = MUL_BITS'(x2n);
                mreq.b = MUL_BITS'(SIN_C9);
            end
            S_H5: begin
                mreq.a = MUL_BITS'(r_x2);
                mreq.b = MUL_BITS'(SIN_C7 - {1'b0, hor});
            end
            S_H3: begin
                mreq.a = MUL_BITS'(r_x2);
                mreq.b = MUL_BITS'(SIN_C5 - {1'b0, hor});
            end
            S_H1: begin
                mreq.a = MUL_BITS'(r_x2);
                mreq.b = MUL_BITS'(SIN_C3 - {1'b0, hor});
            end
            S_S: begin
                // x is t scaled by 2^21, so x*r/2^30 is t*r/2^9
                mreq.a = MUL_BITS'(tw);
                mreq.b = MUL_BITS'(SIN_C1 - {1'b0, hor});
            end
            S_SQ: begin
                mreq.a = MUL_BITS'(s_cl);
                mreq.b = MUL_BITS'(s_cl);
            end
            S_W: begin
                mreq.a = MUL_BITS'(diff_l);
                mreq.b = MUL_BITS'(frac);
            end
            S_IL: begin
                mreq.a = MUL_BITS'(diff_r);
                mreq.b = MUL_BITS'(frac);
            end
            S_IR: begin
                mreq.a = MUL_BITS'(r_win);
                mreq.b = MUL_BITS'(r_il);
            end
            S_AL: begin
                mreq.a = MUL_BITS'(r_win);
                mreq.b = MUL_BITS'(r_ir);
            end
            S_ML: begin
                mreq.a = MUL_BITS'(dry_c);
                mreq.b = MUL_BITS'(r_l);
            end
            S_ML2: begin
                mreq.a = MUL_BITS'(wet_c);
                mreq.b = MUL_BITS'(sl);
            end
            S_MR: begin
                mreq.a = MUL_BITS'(dry_c);
                mreq.b = MUL_BITS'(r_r);
            end
            S_MR2: begin
                mreq.a = MUL_BITS'(wet_c);
                mreq.b = MUL_BITS'(sr);
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = r_en ? S_X2 : S_FIN;
            S_X2:    n_state = S_H7;
            S_H7:    n_state = S_H5;
            S_H5:    n_state = S_H3;
            S_H3:    n_state = S_H1;
            S_H1:    n_state = S_S;
            S_S:     n_state = S_SQ;
            S_SQ:    n_state = S_W;
            S_W:     n_state = S_IL;
            S_IL:    n_state = S_IR;
            S_IR:    n_state = S_AL;
            S_AL:    n_state = S_AR;
            S_AR:    n_state = (r_grain == GRAIN_BITS'(GRAIN_COUNT - 1)) ? S_ML : S_X2;
            S_ML:    n_state = S_ML2;
            S_ML2:   n_state = S_MR;
            S_MR:    n_state = S_MR2;
            S_MR2:   n_state = S_MF;
            S_MF:    n_state = S_FIN;
            S_FIN:   if (out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ratio     <= RATIO_RESET;
            r_wet       <= WET_RESET;
            r_en        <= 1'b1;
            r_wpos      <= '0;
            r_phase     <= '0;
            r_grain     <= '0;
            r_out_valid <= 1'b0;
            for (int g = 0; g < GRAIN_COUNT; g++) begin
                r_pos[g] <= init_pos(g);
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PITCH_RATIO:   r_ratio <= i_cfg_data[RATIO_BITS-1:0];
                    CFG_WET_MIX:       r_wet   <= i_cfg_data[MIX_BITS-1:0];
                    CFG_EFFECT_ENABLE: r_en    <= i_cfg_data[0];
                    default:           ;
                endcase
            end
            if (in_acc && r_en) begin
                r_wpos <= r_wpos + 1'b1;
            end
            if (r_state == S_AR) begin
                // advance read head, restart it when this grain's phase wraps
                if (ph == PHASE_BITS'(GRAIN_LEN - 1)) begin
                    r_pos[r_grain] <= {dpos, {FRAC_BITS{1'b0}}};
                end else begin
                    r_pos[r_grain] <= cur_pos + POS_BITS'(r_ratio);
                end
                r_grain <= r_grain + 1'b1;
                if (r_grain == GRAIN_BITS'(GRAIN_COUNT - 1)) begin
                    r_phase <= r_phase + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_l    <= i_left_sample;
            r_r    <= i_right_sample;
            r_eob  <= i_end_of_block;
            r_resl <= i_left_sample;
            r_resr <= i_right_sample;
            r_accl <= '0;
            r_accr <= '0;
        end
        case (r_state)
            S_H7:  r_x2   <= x2n;
            S_W:   r_win  <= prod[60:44];
            S_IL:  r_il   <= al + prod[39:16];
            S_IR:  r_ir   <= ar + prod[39:16];
            S_AL:  r_accl <= r_accl + prod[44:0];
            S_AR:  r_accr <= r_accr + prod[44:0];
            S_ML2: r_mix  <= prod[47:0];
            S_MR:  r_resl <= sat_sample(mix_sum[47:16]);
            S_MR2: r_mix  <= prod[47:0];
            S_MF:  r_resr <= sat_sample(mix_sum[47:16]);
            default: ;
        endcase
        if (out_load) begin
            r_out_l   <= r_resl;
            r_out_r   <= r_resr;
            r_out_eob <= r_eob;
        end
    end

    gps_ram #(
        .WIDTH     (2 * SAMPLE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ia),
        .i_raddr_b (ib),
        .o_rdata_a (rda),
        .o_rdata_b (rdb)
    );

    gps_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mreq),
        .o_prod (prod)
    );

    `GPS_ASSERT_NXT(a_busy_after_accept, in_acc, o_in_stall, "input taken while busy")
    `GPS_ASSERT_IMP(a_idle_grain_zero, r_state == S_IDLE, r_grain == '0, "grain index off")
    `GPS_ASSERT_NXT(a_wpos_hold, !in_acc, $stable(r_wpos), "write pointer moved")

endmodule
